FILE: src/ezr_pkg.sv
// Package for the ZYX Euler angle to rotation matrix block.
// Holds the CORDIC arctangent table, working widths and word types.
`timescale 1ns / 1ps
package ezr_pkg;

  localparam int WORK_FRAC    = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int XW           = 34;
  localparam int ZW           = 34;
  localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef logic signed [XW-1:0] work_t;

  typedef struct packed {
    work_t s;
    work_t c;
  } sincos_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int idx);
    logic signed [ZW-1:0] v;
    begin
      case (idx)
        0: v = 34'sd536870912;
        1: v = 34'sd316933406;
        2: v = 34'sd167458907;
        3: v = 34'sd85004756;
        4: v = 34'sd42667331;
        5: v = 34'sd21354465;
        6: v = 34'sd10679838;
        7: v = 34'sd5340245;
        8: v = 34'sd2670163;
        9: v = 34'sd1335087;
        10: v = 34'sd667544;
        11: v = 34'sd333772;
        12: v = 34'sd166886;
        13: v = 34'sd83443;
        14: v = 34'sd41722;
        15: v = 34'sd20861;
        16: v = 34'sd10430;
        17: v = 34'sd5215;
        18: v = 34'sd2608;
        19: v = 34'sd1304;
        20: v = 34'sd652;
        21: v = 34'sd326;
        22: v = 34'sd163;
        23: v = 34'sd81;
        24: v = 34'sd41;
        25: v = 34'sd20;
        26: v = 34'sd10;
        27: v = 34'sd5;
        28: v = 34'sd3;
        29: v = 34'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Q4.30 product, round half up, floor.
  function automatic work_t qmul(input work_t a, input work_t b);
    logic signed [2*XW-1:0] p;
    begin
      p = a * b + (68'sd1 <<< (WORK_FRAC - 1));
      return work_t'(p >>> WORK_FRAC);
    end
  endfunction

endpackage

FILE: src/ezr_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per stage, with quadrant fold.
// Depends on ezr_pkg. Stage advance is driven by the shared enable.
`timescale 1ns / 1ps
module ezr_cordic
  import ezr_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output sincos_t                      result
);

  logic [31:0] a32;
  logic        flip_in;
  logic [31:0] af;

  assign a32     = 32'(angle) << (32 - ANGLE_BITS);
  assign flip_in = a32[31] ^ a32[30];
  assign af      = flip_in ? (a32 - 32'h8000_0000) : a32;

  work_t                 x [0:CORDIC_STEPS];
  work_t                 y [0:CORDIC_STEPS];
  logic signed [ZW-1:0]  z [0:CORDIC_STEPS];
  logic                  flip [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CORDIC_X0;
      y[0]    <= '0;
      z[0]    <= ZW'($signed(af));
      flip[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_turn(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_turn(i);
        end
        flip[i+1] <= flip[i];
      end
    end
  end

  assign result.c = flip[CORDIC_STEPS] ? -x[CORDIC_STEPS] : x[CORDIC_STEPS];
  assign result.s = flip[CORDIC_STEPS] ? -y[CORDIC_STEPS] : y[CORDIC_STEPS];

endmodule

FILE: src/ezr_matrix.sv
// Product stages forming the nine matrix entries, then round and saturate.
// Depends on ezr_pkg. Three register stages, advanced by the shared enable.
`timescale 1ns / 1ps
module ezr_matrix
  import ezr_pkg::*;
#(
  parameter int FRACTION_BITS = 14
) (
  input  logic                            clk,
  input  logic                            en,
  input  sincos_t                         ph,
  input  sincos_t                         th,
  input  sincos_t                         ps,
  output logic signed [FRACTION_BITS+1:0] m [0:8]
);

  localparam int SH  = WORK_FRAC - FRACTION_BITS;
  localparam int OW  = FRACTION_BITS + 2;

  work_t spst, cpst, cth1, sth1, cps1, sps1, sph1, cph1;
  work_t p [0:8];
  work_t q [0:8];

  always_ff @(posedge clk) begin
    if (en) begin
      spst <= qmul(ph.s, th.s);
      cpst <= qmul(ph.c, th.s);
      cth1 <= th.c;
      sth1 <= th.s;
      cps1 <= ps.c;
      sps1 <= ps.s;
      sph1 <= ph.s;
      cph1 <= ph.c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= qmul(cth1, cps1);
      p[1] <= qmul(spst, cps1) - qmul(cph1, sps1);
      p[2] <= qmul(cpst, cps1) + qmul(sph1, sps1);
      p[3] <= qmul(cth1, sps1);
      p[4] <= qmul(spst, sps1) + qmul(cph1, cps1);
      p[5] <= qmul(cpst, sps1) - qmul(sph1, cps1);
      p[6] <= -sth1;
      p[7] <= qmul(sph1, cth1);
      p[8] <= qmul(cph1, cth1);
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      q[k] = (p[k] + (work_t'(1) <<< (SH - 1))) >>> SH;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        if (q[k] > (work_t'(1) <<< FRACTION_BITS))
          m[k] <= OW'(1) <<< FRACTION_BITS;
        else if (q[k] < -(work_t'(1) <<< FRACTION_BITS))
          m[k] <= -(OW'(1) <<< FRACTION_BITS);
        else
          m[k] <= OW'(q[k]);
      end
    end
  end

endmodule

FILE: src/euler_zyx_to_rotation_matrix.sv
// ZYX Euler angles to body-to-inertial rotation matrix, fixed point.
// Pipeline: 31 CORDIC stages, 3 product/round stages.
// Throughput: one word per cycle; the whole pipe holds while out stall is high
// and output valid is set.
// Reset: rst clears only the valid bits; data registers are not reset.
// Depends on ezr_pkg, ezr_cordic, ezr_matrix.
`timescale 1ns / 1ps
module euler_zyx_to_rotation_matrix
  import ezr_pkg::*;
#(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [ANGLE_BITS-1:0]    roll_angle,
  input  logic signed [ANGLE_BITS-1:0]    pitch_angle,
  input  logic signed [ANGLE_BITS-1:0]    yaw_angle,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [FRACTION_BITS+1:0] m_row1_col1,
  output logic signed [FRACTION_BITS+1:0] m_row1_col2,
  output logic signed [FRACTION_BITS+1:0] m_row1_col3,
  output logic signed [FRACTION_BITS+1:0] m_row2_col1,
  output logic signed [FRACTION_BITS+1:0] m_row2_col2,
  output logic signed [FRACTION_BITS+1:0] m_row2_col3,
  output logic signed [FRACTION_BITS+1:0] m_row3_col1,
  output logic signed [FRACTION_BITS+1:0] m_row3_col2,
  output logic signed [FRACTION_BITS+1:0] m_row3_col3
);

  localparam int DEPTH = CORDIC_STEPS + 4;

  logic             en;
  logic [DEPTH-1:0] vld;
  sincos_t          ph, th, ps;
  logic signed [FRACTION_BITS+1:0] m [0:8];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .en(en), .angle(roll_angle), .result(ph));
  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .en(en), .angle(pitch_angle), .result(th));
  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .en(en), .angle(yaw_angle), .result(ps));

  ezr_matrix #(.FRACTION_BITS(FRACTION_BITS)) u_matrix (
    .clk(clk), .en(en), .ph(ph), .th(th), .ps(ps), .m(m));

  assign m_row1_col1 = m[0];
  assign m_row1_col2 = m[1];
  assign m_row1_col3 = m[2];
  assign m_row2_col1 = m[3];
  assign m_row2_col2 = m[4];
  assign m_row2_col3 = m[5];
  assign m_row3_col1 = m[6];
  assign m_row3_col2 = m[7];
  assign m_row3_col3 = m[8];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(m_row1_col1))
    else $error("output word changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> m_row3_col3 <= (1 <<< FRACTION_BITS) &&
    m_row3_col3 >= -(1 <<< FRACTION_BITS))
    else $error("entry out of range");

endmodule

FILE: test/ezr_matrix_checker.sv
// Checker for euler_zyx_to_rotation_matrix: watches both channels, predicts
// each rotation matrix with a CORDIC model and compares entry by entry.
// Depends on ezr_pkg for the arctangent table and working widths.
`timescale 1ns / 1ps
module ezr_matrix_checker
  import ezr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] m_row1_col1,
  input  logic signed [15:0] m_row1_col2,
  input  logic signed [15:0] m_row1_col3,
  input  logic signed [15:0] m_row2_col1,
  input  logic signed [15:0] m_row2_col2,
  input  logic signed [15:0] m_row2_col3,
  input  logic signed [15:0] m_row3_col1,
  input  logic signed [15:0] m_row3_col2,
  input  logic signed [15:0] m_row3_col3,
  output int                 fail_count,
  output int                 pending,
  output int                 matrices_seen
);

  typedef logic signed [15:0] entry_t;
  typedef entry_t matrix_t [9];

  // Expected words in flight; the block holds fewer than this.
  matrix_t    exp_mem [0:63];
  logic [5:0] wr_ptr;
  logic [5:0] rd_ptr;
  int         exp_count;

  function automatic longint rshift_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return rshift_floor(a * b + (64'sd1 <<< (WORK_FRAC - 1)), WORK_FRAC);
  endfunction

  task automatic angle_sin_cos(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, dx, dy;
    begin
      a = {ang, 16'h0};
      flip = a[31] ^ a[30];
      if (flip) a = a - 32'h8000_0000;
      z = longint'($signed(a));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = rshift_floor(y, i);
        dy = rshift_floor(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_turn(i));
        end else begin
          x += dx; y -= dy; z += longint'(atan_turn(i));
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    end
  endtask

  function automatic entry_t to_q14(longint v);
    longint r;
    r = rshift_floor(v + (64'sd1 <<< 15), 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return entry_t'(r);
  endfunction

  task automatic predict_matrix(input logic [15:0] r, p, y, output matrix_t m);
    longint sph, cph, sth, cth, sps, cps, spst, cpst;
    begin
      angle_sin_cos(r, sph, cph);
      angle_sin_cos(p, sth, cth);
      angle_sin_cos(y, sps, cps);
      spst = fx_mul(sph, sth);
      cpst = fx_mul(cph, sth);
      m[0] = to_q14(fx_mul(cth, cps));
      m[1] = to_q14(fx_mul(spst, cps) - fx_mul(cph, sps));
      m[2] = to_q14(fx_mul(cpst, cps) + fx_mul(sph, sps));
      m[3] = to_q14(fx_mul(cth, sps));
      m[4] = to_q14(fx_mul(spst, sps) + fx_mul(cph, cps));
      m[5] = to_q14(fx_mul(cpst, sps) - fx_mul(sph, cps));
      m[6] = to_q14(-sth);
      m[7] = to_q14(fx_mul(sph, cth));
      m[8] = to_q14(fx_mul(cph, cth));
    end
  endtask

  assign pending = exp_count;

  always @(posedge clk) begin
    matrix_t m, got;
    bit      popped;
    popped = 1'b0;
    if (rst) begin
      fail_count <= 0;
      matrices_seen <= 0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      exp_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_matrix(roll_angle, pitch_angle, yaw_angle, m);
        exp_mem[wr_ptr] <= m;
        wr_ptr <= wr_ptr + 6'd1;
      end
      if (out_valid && !out_stall) begin
        got = '{m_row1_col1, m_row1_col2, m_row1_col3, m_row2_col1, m_row2_col2,
                m_row2_col3, m_row3_col1, m_row3_col2, m_row3_col3};
        matrices_seen <= matrices_seen + 1;
        if (exp_count == 0) begin
          if (fail_count < 10) $display("unexpected output word at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          m = exp_mem[rd_ptr];
          rd_ptr <= rd_ptr + 6'd1;
          popped = 1'b1;
          if (got != m) begin
            if (fail_count < 10)
              $display("matrix %0d mismatch: exp %p got %p", matrices_seen, m, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      exp_count <= exp_count + ((in_valid && !in_stall) ? 1 : 0) - (popped ? 1 : 0);
    end
  end

endmodule

FILE: test/tb_euler_zyx_to_rotation_matrix.sv
// Testbench top for euler_zyx_to_rotation_matrix: drives angle words with
// random gaps and output stalls; ezr_matrix_checker predicts and compares.
// Depends on ezr_pkg, the block and ezr_matrix_checker.
`timescale 1ns / 1ps
module tb_euler_zyx_to_rotation_matrix;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] roll_angle = '0, pitch_angle = '0, yaw_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  int fail_count, pending, matrices_seen;
  bit quiet_phase = 1'b0;
  bit long_hold = 1'b0;
  int directed_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_zyx_to_rotation_matrix u_dut (
    .clk, .rst, .in_valid, .in_stall, .roll_angle, .pitch_angle, .yaw_angle,
    .out_valid, .out_stall,
    .m_row1_col1(m11), .m_row1_col2(m12), .m_row1_col3(m13),
    .m_row2_col1(m21), .m_row2_col2(m22), .m_row2_col3(m23),
    .m_row3_col1(m31), .m_row3_col2(m32), .m_row3_col3(m33)
  );

  ezr_matrix_checker u_check (
    .clk, .rst, .in_valid, .in_stall, .roll_angle, .pitch_angle, .yaw_angle,
    .out_valid, .out_stall,
    .m_row1_col1(m11), .m_row1_col2(m12), .m_row1_col3(m13),
    .m_row2_col1(m21), .m_row2_col2(m22), .m_row2_col3(m23),
    .m_row3_col1(m31), .m_row3_col2(m32), .m_row3_col3(m33),
    .fail_count, .pending, .matrices_seen
  );

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000 + 16'($urandom_range(0, 3)) - 16'd2;
      1: return 16'h4000 + 16'($urandom_range(0, 3)) - 16'd2;
      2: return 16'hC000 + 16'($urandom_range(0, 3)) - 16'd2;
      3: return 16'($urandom_range(0, 3)) - 16'd2;
      default: return 16'($urandom());
    endcase
  endfunction

  // Offer one word and hold it until the block takes it; valid stays high
  // afterwards unless a gap follows.
  task automatic send_word(input logic [15:0] r, p, y, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    roll_angle <= r;
    pitch_angle <= p;
    yaw_angle <= y;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Output side: random stall bursts, one long hold-off, none at the end.
  initial begin
    @(negedge clk);
    while (1) begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
    end
  end

  initial begin
    logic [15:0] corner [8];
    int waited;
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000,
               16'h3FFF, 16'hBFFF};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_count = 0;
    for (int i = 0; i < 8; i++) begin
      send_word(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8], 1'b0);
      send_word(corner[i], corner[i], corner[i], 1'b0);
      directed_count += 2;
    end
    send_word(16'h1555, 16'h2AAA, 16'hD555, 1'b0);
    in_valid <= 1'b0;
    // Sender pause until everything is drained.
    while (pending != 0) @(negedge clk);
    long_hold = 1'b1;
    for (int i = 0; i < 80; i++)
      send_word(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
    for (int i = 0; i < 820; i++) begin
      if (i == 700) quiet_phase = 1'b1;
      send_word(pick_angle(), pick_angle(), pick_angle(), !quiet_phase);
    end
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (50) @(negedge clk);
    $display("sent %0d angle triples (%0d directed); %0d matrices checked",
             directed_count + 901, directed_count + 1, matrices_seen);
    if (fail_count == 0 && pending == 0)
      $display("tb_euler_zyx_to_rotation_matrix OK");
    else
      $display("tb_euler_zyx_to_rotation_matrix NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_euler_zyx_to_rotation_matrix NOT OK");
    $finish;
  end

endmodule
